@@ sv/nwc_pkg.sv @@
// Shared types, constants and helpers of the normalized window convolution.
package nwc_pkg;

	localparam int PIXEL_BITS_DEF  = 12;
	localparam int WEIGHT_BITS_DEF = 16;

	localparam int FIELD_BITS = 12;
	localparam int SLOT_BITS  = 16;
	localparam int ROW_BITS   = 48;
	localparam int TAPS       = 9;
	localparam int ROWS       = 3;
	localparam int TAPS_PER_ROW = TAPS / ROWS;

	localparam int QUOT_BITS = 12;
	localparam int OUT_BITS  = 13;
	localparam logic [QUOT_BITS-1:0] OUT_MAX = 12'd4095;

	localparam int ADDR_BITS = 5;
	localparam int DATA_BITS = 64;

	localparam logic [ROW_BITS-1:0] TOP_RESET    = 48'h0000_0000_0000;
	localparam logic [ROW_BITS-1:0] MIDDLE_RESET = 48'h0000_0001_0000;
	localparam logic [ROW_BITS-1:0] BOTTOM_RESET = 48'h0000_0000_0000;

	typedef enum logic [1:0] {
		REG_TOP    = 2'd0,
		REG_MIDDLE = 2'd1,
		REG_BOTTOM = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [FIELD_BITS-1:0] pixel_nw;
		logic [FIELD_BITS-1:0] pixel_n;
		logic [FIELD_BITS-1:0] pixel_ne;
		logic [FIELD_BITS-1:0] pixel_w;
		logic [FIELD_BITS-1:0] pixel_c;
		logic [FIELD_BITS-1:0] pixel_e;
		logic [FIELD_BITS-1:0] pixel_sw;
		logic [FIELD_BITS-1:0] pixel_s;
		logic [FIELD_BITS-1:0] pixel_se;
		logic [TAPS-1:0]       inside_mask;
	} item_t;

	typedef struct packed {
		logic signed [OUT_BITS-1:0] filtered_value;
		logic                       zero_weight_sum;
	} result_t;

	// Control that travels alongside an item through the merge and divider stages.
	typedef struct packed {
		logic valid;
		logic neg;
		logic zero;
		logic sat;
	} div_ctl_t;

	function automatic logic [FIELD_BITS-1:0] pixel_of(input item_t it, input int k);
		logic [FIELD_BITS-1:0] p;
		case (k)
			0: p = it.pixel_nw;
			1: p = it.pixel_n;
			2: p = it.pixel_ne;
			3: p = it.pixel_w;
			4: p = it.pixel_c;
			5: p = it.pixel_e;
			6: p = it.pixel_sw;
			7: p = it.pixel_s;
			8: p = it.pixel_se;
			default: p = '0;
		endcase
		return p;
	endfunction

endpackage

@@ sv/nwc_lane.sv @@
// One multiplier lane: weight times pixel for a single neighbor, gated by its mask bit.
module nwc_lane #(
	parameter int PIXEL_BITS  = nwc_pkg::PIXEL_BITS_DEF,
	parameter int WEIGHT_BITS = nwc_pkg::WEIGHT_BITS_DEF
) (
	input  logic                                    clk,
	input  logic [nwc_pkg::SLOT_BITS-1:0]           slot,
	input  logic [nwc_pkg::FIELD_BITS-1:0]          pixel,
	input  logic                                    in_image,
	output logic signed [PIXEL_BITS+WEIGHT_BITS:0]  prod_s1
);

	logic signed [WEIGHT_BITS-1:0] weight;
	logic [PIXEL_BITS-1:0]         pix;
	logic signed [PIXEL_BITS:0]    pix_s;

	assign weight = slot[WEIGHT_BITS-1:0];
	assign pix    = PIXEL_BITS'(pixel);
	assign pix_s  = {1'b0, pix};

	// A neighbor outside the image contributes nothing.
	always_ff @(posedge clk) begin
		if (in_image) begin
			prod_s1 <= weight * pix_s;
		end else begin
			prod_s1 <= '0;
		end
	end

endmodule

@@ sv/nwc_merge.sv @@
// Merge stage: adds the lane products, forms the rounding dividend and the weight sum.
module nwc_merge #(
	parameter int PIXEL_BITS  = nwc_pkg::PIXEL_BITS_DEF,
	parameter int WEIGHT_BITS = nwc_pkg::WEIGHT_BITS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    valid_s1,
	input  logic signed [PIXEL_BITS+WEIGHT_BITS:0]  prod_s1 [nwc_pkg::TAPS],
	input  logic [nwc_pkg::ROW_BITS-1:0]            rows [nwc_pkg::ROWS],
	output nwc_pkg::div_ctl_t                       ctl_s4,
	output logic [PIXEL_BITS+WEIGHT_BITS+4:0]       n_s4,
	output logic [WEIGHT_BITS+2:0]                  den_q
);

	localparam int PW    = PIXEL_BITS + WEIGHT_BITS + 1;
	localparam int RSW   = PW + 2;
	localparam int NUMW  = PW + 3;
	localparam int NW    = NUMW + 1;
	localparam int DEN_W = WEIGHT_BITS + 3;

	logic signed [RSW-1:0]  row_sum_d [nwc_pkg::ROWS];
	logic signed [RSW-1:0]  row_sum_s2 [nwc_pkg::ROWS];
	logic signed [NUMW-1:0] num_s3;
	logic [NUMW-1:0]        mag;
	logic [DEN_W-1:0]       row_den_d [nwc_pkg::ROWS];
	logic [DEN_W-1:0]       row_den_q [nwc_pkg::ROWS];
	logic                   valid_s2;
	logic                   valid_s3;

	// Row sums of the products and of the absolute weights.
	always_comb begin
		logic [WEIGHT_BITS-1:0] w;
		logic [WEIGHT_BITS-1:0] wa;
		for (int r = 0; r < nwc_pkg::ROWS; r++) begin
			row_sum_d[r] = RSW'(prod_s1[nwc_pkg::TAPS_PER_ROW*r])
				+ RSW'(prod_s1[nwc_pkg::TAPS_PER_ROW*r+1])
				+ RSW'(prod_s1[nwc_pkg::TAPS_PER_ROW*r+2]);
			row_den_d[r] = '0;
			for (int s = 0; s < nwc_pkg::TAPS_PER_ROW; s++) begin
				w  = rows[r][s*nwc_pkg::SLOT_BITS +: WEIGHT_BITS];
				wa = w[WEIGHT_BITS-1] ? (~w + 1'b1) : w;
				row_den_d[r] = row_den_d[r] + DEN_W'(wa);
			end
		end
	end

	// The weight sum follows the registers, through row_den_q and then den_q.
	always_ff @(posedge clk) begin
		row_den_q <= row_den_d;
		den_q     <= row_den_q[0] + row_den_q[1] + row_den_q[2];
	end

	always_ff @(posedge clk) begin
		row_sum_s2 <= row_sum_d;
		num_s3     <= NUMW'(row_sum_s2[0]) + NUMW'(row_sum_s2[1]) + NUMW'(row_sum_s2[2]);
	end

	always_comb begin
		mag = num_s3[NUMW-1] ? NUMW'(-num_s3) : NUMW'(num_s3);
	end

	// Dividend for round half away from zero: 2*|num| + den over 2*den.
	always_ff @(posedge clk) begin
		n_s4 <= {mag, 1'b0} + NW'(den_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			ctl_s4   <= '0;
		end else begin
			valid_s2     <= valid_s1;
			valid_s3     <= valid_s2;
			ctl_s4.valid <= valid_s3;
			ctl_s4.neg   <= num_s3[NUMW-1];
			ctl_s4.zero  <= (den_q == '0);
			ctl_s4.sat   <= 1'b0;
		end
	end

endmodule

@@ sv/nwc_divider.sv @@
// Pipelined restoring divider: overflow check, then one quotient bit per stage.
module nwc_divider #(
	parameter int PIXEL_BITS  = nwc_pkg::PIXEL_BITS_DEF,
	parameter int WEIGHT_BITS = nwc_pkg::WEIGHT_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  nwc_pkg::div_ctl_t                   ctl_in,
	input  logic [PIXEL_BITS+WEIGHT_BITS+4:0]   n_in,
	input  logic [WEIGHT_BITS+2:0]              den,
	output nwc_pkg::div_ctl_t                   ctl_out,
	output logic [nwc_pkg::QUOT_BITS-1:0]       quot
);

	localparam int QB    = nwc_pkg::QUOT_BITS;
	localparam int NW    = PIXEL_BITS + WEIGHT_BITS + 5;
	localparam int DEN_W = WEIGHT_BITS + 3;
	localparam int LIM_W = DEN_W + 1 + QB;
	localparam int RW    = (NW > LIM_W) ? NW : LIM_W;

	logic [RW-1:0]     dd_w;
	logic [RW-1:0]     lim;
	logic              ov;
	logic [RW-1:0]     rem_s [QB];
	logic [QB-1:0]     q_s   [QB+1];
	nwc_pkg::div_ctl_t ctl_s [QB+1];

	assign dd_w = RW'({den, 1'b0});
	assign lim  = dd_w << QB;
	assign ov   = RW'(n_in) >= lim;

	// Quotients beyond the output range are caught here and saturate at the output, so the steps never overflow.
	always_ff @(posedge clk) begin
		rem_s[0] <= ov ? '0 : RW'(n_in);
		q_s[0]   <= '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s[0] <= '0;
		end else begin
			ctl_s[0] <= '{valid: ctl_in.valid, neg: ctl_in.neg, zero: ctl_in.zero, sat: ov};
		end
	end

	for (genvar j = 1; j <= QB; j++) begin : g_step
		localparam int SH = QB - j;
		logic [RW-1:0] sub;
		logic          take;

		assign sub  = dd_w << SH;
		assign take = rem_s[j-1] >= sub;

		always_ff @(posedge clk) begin
			q_s[j] <= {q_s[j-1][QB-2:0], take};
		end

		if (j < QB) begin : g_rem
			always_ff @(posedge clk) begin
				rem_s[j] <= take ? rem_s[j-1] - sub : rem_s[j-1];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[j] <= '0;
			end else begin
				ctl_s[j] <= ctl_s[j-1];
			end
		end
	end

	assign ctl_out = ctl_s[QB];
	assign quot    = ctl_s[QB].sat ? nwc_pkg::OUT_MAX : q_s[QB];

endmodule

@@ sv/normalized_window_convolution.sv @@
// Top level of the 3x3 normalized window convolution with its register port.
// A result reaches the result port through the lane, merge, divider and output registers.
// Throughput: one item per clock; nine multiplier lanes and a divider pipeline that retires
// one quotient bit per stage keep every stage busy, so busy never rises.
// Reset (arst_n low) clears the pipeline valid bits and loads the identity kernel.
// The receiver cannot stall: each result is shown for exactly one cycle under done.
module normalized_window_convolution #(
	parameter int PIXEL_BITS  = nwc_pkg::PIXEL_BITS_DEF,
	parameter int WEIGHT_BITS = nwc_pkg::WEIGHT_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  nwc_pkg::item_t                    item,
	output logic                              done,
	output nwc_pkg::result_t                  result,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [nwc_pkg::ADDR_BITS-1:0]     paddr,
	input  logic [nwc_pkg::DATA_BITS-1:0]     pwdata,
	output logic [nwc_pkg::DATA_BITS-1:0]     prdata,
	output logic                              pready
);

	localparam int PW    = PIXEL_BITS + WEIGHT_BITS + 1;
	localparam int NW    = PIXEL_BITS + WEIGHT_BITS + 5;
	localparam int DEN_W = WEIGHT_BITS + 3;
	// Edges from acceptance to the edge at which done is first sampled high.
	localparam int SAMPLE_LAT = 6 + nwc_pkg::QUOT_BITS;

	logic [nwc_pkg::ROW_BITS-1:0]  weights_q [nwc_pkg::ROWS];
	nwc_pkg::reg_idx_t             reg_idx;
	logic                          wr_en;
	logic                          valid_s1;
	logic signed [PW-1:0]          prod_s1 [nwc_pkg::TAPS];
	nwc_pkg::div_ctl_t             ctl_s4;
	logic [NW-1:0]                 n_s4;
	logic [DEN_W-1:0]              den;
	nwc_pkg::div_ctl_t             div_ctl;
	logic [nwc_pkg::QUOT_BITS-1:0] quot;
	logic signed [nwc_pkg::OUT_BITS-1:0] value_d;
	logic signed [nwc_pkg::OUT_BITS-1:0] qmag;
	logic                          done_q;
	nwc_pkg::result_t              result_q;

	// Every stage advances each cycle, so a new item is taken on every clock.
	assign busy   = 1'b0;
	assign pready = 1'b1;

	// ------------------------------------------------------------------
	// Register port. Each weight row is 48 bits and sits on an 8-byte
	// boundary; address bits below that are ignored. A write to the unused
	// fourth slot is dropped and that slot reads as zero.
	// ------------------------------------------------------------------
	assign reg_idx = nwc_pkg::reg_idx_t'(paddr[nwc_pkg::ADDR_BITS-1:3]);
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weights_q[0] <= nwc_pkg::TOP_RESET;
			weights_q[1] <= nwc_pkg::MIDDLE_RESET;
			weights_q[2] <= nwc_pkg::BOTTOM_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				nwc_pkg::REG_TOP:    weights_q[0] <= pwdata[nwc_pkg::ROW_BITS-1:0];
				nwc_pkg::REG_MIDDLE: weights_q[1] <= pwdata[nwc_pkg::ROW_BITS-1:0];
				nwc_pkg::REG_BOTTOM: weights_q[2] <= pwdata[nwc_pkg::ROW_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			nwc_pkg::REG_TOP:    prdata = nwc_pkg::DATA_BITS'(weights_q[0]);
			nwc_pkg::REG_MIDDLE: prdata = nwc_pkg::DATA_BITS'(weights_q[1]);
			nwc_pkg::REG_BOTTOM: prdata = nwc_pkg::DATA_BITS'(weights_q[2]);
			default:             prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Nine lanes, one per neighbor, in the order nw, n, ne, w, c, e, sw,
	// s, se. Lane k takes its weight from the matching 16-bit slot of its
	// row register.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	for (genvar k = 0; k < nwc_pkg::TAPS; k++) begin : g_lane
		localparam int ROW  = k / nwc_pkg::TAPS_PER_ROW;
		localparam int SLOT = k % nwc_pkg::TAPS_PER_ROW;

		nwc_lane #(
			.PIXEL_BITS  (PIXEL_BITS),
			.WEIGHT_BITS (WEIGHT_BITS)
		) u_lane (
			.clk      (clk),
			.slot     (weights_q[ROW][SLOT*nwc_pkg::SLOT_BITS +: nwc_pkg::SLOT_BITS]),
			.pixel    (nwc_pkg::pixel_of(item, k)),
			.in_image (item.inside_mask[k]),
			.prod_s1  (prod_s1[k])
		);
	end

	// The merge stage sums the products in a registered tree and builds the
	// dividend 2*|sum| + den; the divisor is 2*den, so the quotient is the
	// rounded magnitude.
	nwc_merge #(
		.PIXEL_BITS  (PIXEL_BITS),
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.prod_s1  (prod_s1),
		.rows     (weights_q),
		.ctl_s4   (ctl_s4),
		.n_s4     (n_s4),
		.den_q    (den)
	);

	nwc_divider #(
		.PIXEL_BITS  (PIXEL_BITS),
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_divider (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl_in  (ctl_s4),
		.n_in    (n_s4),
		.den     (den),
		.ctl_out (div_ctl),
		.quot    (quot)
	);

	// Apply the sign and force zero when every weight is zero.
	always_comb begin
		qmag = nwc_pkg::OUT_BITS'(quot);
		if (div_ctl.zero) begin
			value_d = '0;
		end else if (div_ctl.neg) begin
			value_d = -qmag;
		end else begin
			value_d = qmag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= div_ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		result_q.filtered_value  <= value_d;
		result_q.zero_weight_sum <= div_ctl.zero;
	end

	assign done   = done_q;
	assign result = result_q;

	// ------------------------------------------------------------------
	// Checks.
	// ------------------------------------------------------------------
	a_fixed_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##SAMPLE_LAT done)
		else $error("accepted item did not produce a result at the fixed latency");

	a_zero_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.zero_weight_sum == (den == '0)))
		else $error("zero weight flag disagrees with the weight sum");

	a_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.zero_weight_sum |-> result.filtered_value == '0)
		else $error("zero weight sum gave a nonzero value");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.filtered_value != 13'sh1000)
		else $error("filtered value left the saturation range");

endmodule
